### src/tss_pkg.sv
// shared types and constants of the tridiagonal system solver
// no dependencies
`default_nettype none
package tss_pkg;
   localparam int DATA_W = 32;
   localparam int ROW_INDEX_W = 6;
   localparam int CSR_W = 7;
   localparam logic [CSR_W-1:0] N_ROWS_RESET = 7'd64;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [ROW_INDEX_W-1:0] row_index_type;

   localparam data_type DATA_MAX = 32'sh7fffffff;
   localparam data_type DATA_MIN = 32'sh80000000;
endpackage
`default_nettype wire

### src/tss_channels.sv
// request and response channel interfaces of the solver
// depends on tss_pkg
`default_nettype none
interface tss_req_if;
   import tss_pkg::*;
   logic     valid;
   logic     ready;
   data_type sub_diag;
   data_type main_diag;
   data_type super_diag;
   data_type rhs;
   modport source (output valid, sub_diag, main_diag, super_diag, rhs, input ready);
   modport sink (input valid, sub_diag, main_diag, super_diag, rhs, output ready);
endinterface

interface tss_rsp_if;
   import tss_pkg::*;
   logic          valid;
   logic          ready;
   data_type      solution;
   row_index_type row_index;
   logic          last_flag;
   logic          zero_pivot;
   modport source (output valid, solution, row_index, last_flag, zero_pivot, input ready);
   modport sink (input valid, solution, row_index, last_flag, zero_pivot, output ready);
endinterface
`default_nettype wire

### src/tss_divider.sv
// iterative q16.16 divider, one quotient bit per cycle, rounded and saturated
// depends on tss_pkg
`default_nettype none
module tss_divider (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  tss_pkg::data_type num,
   input  tss_pkg::data_type den,
   output logic              done,
   output tss_pkg::data_type quotient
);
   import tss_pkg::*;

   localparam int QUO_W = 48;
   localparam int CNT_W = 6;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       den_mag_ff, den_mag_in;
   logic              neg_ff, neg_in;
   data_type          result_ff, result_in;

   logic [32:0]       num_ext, den_ext, num_abs, den_abs;
   logic [32:0]       rem_sh, rem_diff;
   logic [QUO_W-1:0]  quo_clamp;

   always_comb begin
      num_ext = {num[DATA_W-1], num};
      den_ext = {den[DATA_W-1], den};
      num_abs = num[DATA_W-1] ? (33'd0 - num_ext) : num_ext;
      den_abs = den[DATA_W-1] ? (33'd0 - den_ext) : den_ext;
      rem_sh = {rem_ff, quo_ff[QUO_W-1]};
      rem_diff = rem_sh - {1'b0, den_mag_ff};
      quo_clamp = (quo_ff > 48'h80000000) ? 48'h80000000 : quo_ff;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_mag_in = den_mag_ff;
      neg_in = neg_ff;
      result_in = result_ff;
      priority if (start) begin
         if (den == '0) begin
            done_in = 1'b1;
            priority if (num == '0) result_in = '0;
            else if (num[DATA_W-1]) result_in = DATA_MIN;
            else result_in = DATA_MAX;
         end else begin
            busy_in = 1'b1;
            cnt_in = CNT_W'(QUO_W);
            neg_in = num[DATA_W-1] ^ den[DATA_W-1];
            den_mag_in = den_abs[31:0];
            rem_in = '0;
            quo_in = {num_abs[31:0], 16'd0} + QUO_W'(den_abs[31:1]);
         end
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!rem_diff[32]) begin
            rem_in = rem_diff[31:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
         done_in = 1'b1;
         if (neg_ff) result_in = data_type'(32'd0 - quo_clamp[31:0]);
         else if (quo_clamp[31]) result_in = DATA_MAX;
         else result_in = data_type'(quo_clamp[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_mag_ff <= den_mag_in;
      neg_ff <= neg_in;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign quotient = result_ff;
endmodule
`default_nettype wire

### src/tss_multiplier.sv
// two-stage q16.16 multiplier with round half away from zero and saturation
// depends on tss_pkg
`default_nettype none
module tss_multiplier (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  tss_pkg::data_type op_a,
   input  tss_pkg::data_type op_b,
   output logic              done,
   output tss_pkg::data_type product
);
   import tss_pkg::*;

   logic               stage1_ff, done_ff;
   logic signed [63:0] prod_ff;
   data_type           result_ff, result_in;
   logic [63:0]        mag;
   logic [47:0]        rounded;

   always_comb begin
      mag = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
      rounded = 48'((mag + 64'h8000) >> 16);
      if (prod_ff[63]) begin
         if (rounded > 48'h80000000) result_in = DATA_MIN;
         else result_in = data_type'(32'd0 - rounded[31:0]);
      end else begin
         if (rounded > 48'h7fffffff) result_in = DATA_MAX;
         else result_in = data_type'(rounded[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         stage1_ff <= start;
         done_ff <= stage1_ff;
      end
      prod_ff <= op_a * op_b;
      result_ff <= result_in;
   end

   assign done = done_ff;
   assign product = result_ff;
endmodule
`default_nettype wire

### src/tridiagonal_system_solver.sv
// top level of the tridiagonal system solver: sequencer, row stores, output register
// depends on tss_pkg, tss_channels, tss_divider, tss_multiplier
// req_chan: one transaction per row of the system, row 0 first, signed q16.16
// coefficients. csr_wr_en/csr_wr_data set n_rows (reset 64, zero counts as one,
// above MAX_ROWS counts as MAX_ROWS); write it only while the block is idle.
// rsp_chan: after the last row, one transaction per row from the last row down
// to row 0; last_flag marks row 0, zero_pivot tells whether any pivot was zero.
// a row other than row 0 goes through one divide (on the shared bit-serial divider;
// a zero divisor skips the iteration), two products on the shared multiplier, a
// store write and the accept. row 0 needs only the accept and the store write. each
// back substitution result needs a store read, one product, one divide and the output
// state; the last row needs only the divide. req_ready is low while a row or a back
// substitution is in progress. a stalled receiver holds the current result in the
// output register and halts back substitution until it is taken. reset clears the row
// count, the zero pivot flag and the output valid; the row stores need no clearing.
`default_nettype none
module tridiagonal_system_solver #(
   parameter int MAX_ROWS = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   tss_req_if.sink                   req_chan,
   tss_rsp_if.source                 rsp_chan,
   input  wire                       csr_wr_en,
   input  wire [tss_pkg::CSR_W-1:0]  csr_wr_data
);
   import tss_pkg::*;

   localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] S_FDIV   = 4'd1;
   localparam logic [ST_W-1:0] S_FMULU  = 4'd2;
   localparam logic [ST_W-1:0] S_FMULR  = 4'd3;
   localparam logic [ST_W-1:0] S_FWRITE = 4'd4;
   localparam logic [ST_W-1:0] S_BDIV   = 4'd5;
   localparam logic [ST_W-1:0] S_OUT    = 4'd6;
   localparam logic [ST_W-1:0] S_BREAD  = 4'd7;
   localparam logic [ST_W-1:0] S_BISSUE = 4'd8;
   localparam logic [ST_W-1:0] S_BMUL   = 4'd9;

   function automatic data_type sat_sub(input data_type a, input data_type b);
      logic signed [DATA_W:0] d;
      begin
         d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
         if (d[DATA_W] != d[DATA_W-1]) sat_sub = d[DATA_W] ? DATA_MIN : DATA_MAX;
         else sat_sub = data_type'(d[DATA_W-1:0]);
      end
   endfunction

   logic [ST_W-1:0]   state_ff, state_in;
   logic [CSR_W-1:0]  n_rows_ff;
   logic [ADDR_W-1:0] row_count_ff, row_count_in;
   logic [ADDR_W-1:0] r_ff, r_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic              flag_ff, flag_in;
   data_type          dia_ff, dia_in, sup_ff, sup_in, rhs_ff, rhs_in;
   data_type          f_ff, f_in, piv_new_ff, piv_new_in, rrhs_new_ff, rrhs_new_in;
   data_type          prev_piv_ff, prev_piv_in, prev_up_ff, prev_up_in;
   data_type          prev_rrhs_ff, prev_rrhs_in;
   logic              out_valid_ff, out_valid_in;
   data_type          out_sol_ff, out_sol_in;
   logic              out_last_ff, out_last_in, out_zp_ff, out_zp_in;
   logic [ADDR_W-1:0] out_row_ff, out_row_in;

   data_type          pivot_mem [MAX_ROWS];
   data_type          upper_mem [MAX_ROWS];
   data_type          rrhs_mem [MAX_ROWS];
   data_type          piv_rd_ff, up_rd_ff, rrhs_rd_ff;
   logic              wr_en;

   logic              div_start, div_done, mul_start, mul_done;
   data_type          div_num, div_den, div_q, mul_a, mul_b, mul_p;
   logic [CSR_W-1:0]  n_eff, r_next;
   logic              req_fire, rsp_fire;

   tss_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quotient(div_q)
   );

   tss_multiplier u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .product(mul_p)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = out_valid_ff && rsp_chan.ready;

   always_comb begin
      priority if (n_rows_ff == '0) n_eff = CSR_W'(1);
      else if (n_rows_ff > CSR_W'(MAX_ROWS)) n_eff = CSR_W'(MAX_ROWS);
      else n_eff = n_rows_ff;
      r_next = CSR_W'(r_ff) + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      row_count_in = row_count_ff;
      r_in = r_ff;
      k_in = k_ff;
      flag_in = flag_ff;
      dia_in = dia_ff;
      sup_in = sup_ff;
      rhs_in = rhs_ff;
      f_in = f_ff;
      piv_new_in = piv_new_ff;
      rrhs_new_in = rrhs_new_ff;
      prev_piv_in = prev_piv_ff;
      prev_up_in = prev_up_ff;
      prev_rrhs_in = prev_rrhs_ff;
      out_valid_in = out_valid_ff;
      out_sol_in = out_sol_ff;
      out_last_in = out_last_ff;
      out_zp_in = out_zp_ff;
      out_row_in = out_row_ff;
      wr_en = 1'b0;
      div_start = 1'b0;
      div_num = req_chan.sub_diag;
      div_den = prev_piv_ff;
      mul_start = 1'b0;
      mul_a = div_q;
      mul_b = prev_up_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               dia_in = req_chan.main_diag;
               sup_in = req_chan.super_diag;
               rhs_in = req_chan.rhs;
               r_in = row_count_ff;
               if (row_count_ff == '0) begin
                  piv_new_in = req_chan.main_diag;
                  rrhs_new_in = req_chan.rhs;
                  state_in = S_FWRITE;
               end else begin
                  div_start = 1'b1;
                  state_in = S_FDIV;
               end
            end
         end
         S_FDIV: begin
            if (div_done) begin
               f_in = div_q;
               mul_start = 1'b1;
               state_in = S_FMULU;
            end
         end
         S_FMULU: begin
            if (mul_done) begin
               piv_new_in = sat_sub(dia_ff, mul_p);
               mul_a = f_ff;
               mul_b = prev_rrhs_ff;
               mul_start = 1'b1;
               state_in = S_FMULR;
            end
         end
         S_FMULR: begin
            if (mul_done) begin
               rrhs_new_in = sat_sub(rhs_ff, mul_p);
               state_in = S_FWRITE;
            end
         end
         S_FWRITE: begin
            wr_en = 1'b1;
            prev_piv_in = piv_new_ff;
            prev_up_in = sup_ff;
            prev_rrhs_in = rrhs_new_ff;
            if (piv_new_ff == '0) flag_in = 1'b1;
            if (r_next < n_eff) begin
               row_count_in = ADDR_W'(r_next);
               state_in = S_IDLE;
            end else begin
               k_in = r_ff;
               div_num = rrhs_new_ff;
               div_den = piv_new_ff;
               div_start = 1'b1;
               state_in = S_BDIV;
            end
         end
         S_BDIV: begin
            if (div_done) begin
               out_valid_in = 1'b1;
               out_sol_in = div_q;
               out_row_in = k_ff;
               out_last_in = (k_ff == '0);
               out_zp_in = flag_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               out_valid_in = 1'b0;
               if (k_ff == '0) begin
                  row_count_in = '0;
                  flag_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff - 1'b1;
                  state_in = S_BREAD;
               end
            end
         end
         S_BREAD: begin
            state_in = S_BISSUE;
         end
         S_BISSUE: begin
            mul_a = up_rd_ff;
            mul_b = out_sol_ff;
            mul_start = 1'b1;
            state_in = S_BMUL;
         end
         S_BMUL: begin
            if (mul_done) begin
               div_num = sat_sub(rrhs_rd_ff, mul_p);
               div_den = piv_rd_ff;
               div_start = 1'b1;
               state_in = S_BDIV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_rows_ff <= N_ROWS_RESET;
         row_count_ff <= '0;
         flag_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) n_rows_ff <= csr_wr_data;
         row_count_ff <= row_count_in;
         flag_ff <= flag_in;
         out_valid_ff <= out_valid_in;
      end
      r_ff <= r_in;
      k_ff <= k_in;
      dia_ff <= dia_in;
      sup_ff <= sup_in;
      rhs_ff <= rhs_in;
      f_ff <= f_in;
      piv_new_ff <= piv_new_in;
      rrhs_new_ff <= rrhs_new_in;
      prev_piv_ff <= prev_piv_in;
      prev_up_ff <= prev_up_in;
      prev_rrhs_ff <= prev_rrhs_in;
      out_sol_ff <= out_sol_in;
      out_last_ff <= out_last_in;
      out_zp_ff <= out_zp_in;
      out_row_ff <= out_row_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pivot_mem[r_ff] <= piv_new_ff;
         upper_mem[r_ff] <= sup_ff;
         rrhs_mem[r_ff] <= rrhs_new_ff;
      end
      piv_rd_ff <= pivot_mem[k_ff];
      up_rd_ff <= upper_mem[k_ff];
      rrhs_rd_ff <= rrhs_mem[k_ff];
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.solution = out_sol_ff;
   assign rsp_chan.row_index = ROW_INDEX_W'(out_row_ff);
   assign rsp_chan.last_flag = out_last_ff;
   assign rsp_chan.zero_pivot = out_zp_ff;
endmodule
`default_nettype wire
